/* src/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants for the drain/fill sequencer
// Operation, phase and event codes, register indexes and the config struct.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;
    localparam int unsigned SalWidth      = 16;
    localparam int unsigned TickWidth     = 32;

    // Register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] CFG_SALT_MODE    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_SALINITY_MIN = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_SALINITY_MAX = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_DRAIN_LIMIT  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_FILL_LIMIT   = 3'd4;

    // Register reset values
    localparam logic [SalWidth-1:0]  SALINITY_MIN_RST = 16'd0;
    localparam logic [SalWidth-1:0]  SALINITY_MAX_RST = 16'hFFFF;
    localparam logic [TickWidth-1:0] DRAIN_LIMIT_RST  = 32'd600000;
    localparam logic [TickWidth-1:0] FILL_LIMIT_RST   = 32'd600000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_ABORT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRAIN = 2'd1,
        PH_FILL  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_STARTED    = 4'd1,
        EV_SKIP_SAL   = 4'd2,
        EV_SKIP_LEVEL = 4'd3,
        EV_DRAIN_DONE = 4'd4,
        EV_DRAIN_TMO  = 4'd5,
        EV_FILL_DONE  = 4'd6,
        EV_BARREL_LOW = 4'd7,
        EV_FILL_TMO   = 4'd8,
        EV_ABORTED    = 4'd9
    } event_t;

    typedef struct packed {
        logic                 salt_mode;
        logic [SalWidth-1:0]  salinity_min;
        logic [SalWidth-1:0]  salinity_max;
        logic [TickWidth-1:0] drain_limit;
        logic [TickWidth-1:0] fill_limit;
    } cfg_t;

    // One input transaction after unpacking
    typedef struct packed {
        logic [1:0]          operation;
        logic                tank_low_hit;
        logic                tank_high_hit;
        logic                barrel_low_hit;
        logic                tank_level_low;
        logic                barrel_level_low;
        logic [SalWidth-1:0] barrel_salinity;
    } item_t;

endpackage

/* src/dfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dfs_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module dfs_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dfs_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [dfs_pkg::CfgDataWidth-1:0]      cfg_data,
    output dfs_pkg::cfg_t                         cfg
);

    dfs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.salt_mode    <= 1'b0;
            cfg_reg.salinity_min <= dfs_pkg::SALINITY_MIN_RST;
            cfg_reg.salinity_max <= dfs_pkg::SALINITY_MAX_RST;
            cfg_reg.drain_limit  <= dfs_pkg::DRAIN_LIMIT_RST;
            cfg_reg.fill_limit   <= dfs_pkg::FILL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            // indexes beyond the list are dropped
            unique case (cfg_index)
                dfs_pkg::CFG_SALT_MODE:    cfg_reg.salt_mode    <= cfg_data[0];
                dfs_pkg::CFG_SALINITY_MIN: cfg_reg.salinity_min <= cfg_data[15:0];
                dfs_pkg::CFG_SALINITY_MAX: cfg_reg.salinity_max <= cfg_data[15:0];
                dfs_pkg::CFG_DRAIN_LIMIT:  cfg_reg.drain_limit  <= cfg_data;
                dfs_pkg::CFG_FILL_LIMIT:   cfg_reg.fill_limit   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/dfs_step.sv */
// ----------------------------------------------------------------------------
// dfs_step: next-state logic of the sequencer
// Computes next phase, next tick count and event for one transaction.
// ----------------------------------------------------------------------------
module dfs_step
(
    input  dfs_pkg::cfg_t                     cfg,
    input  dfs_pkg::item_t                    item,
    input  dfs_pkg::phase_t                   phase,
    input  logic [dfs_pkg::TickWidth-1:0]     elapsed,
    output dfs_pkg::phase_t                   phase_next,
    output logic [dfs_pkg::TickWidth-1:0]     elapsed_next,
    output dfs_pkg::event_t                   ev
);

    logic [dfs_pkg::TickWidth-1:0] elapsed_inc;
    logic                          drain_expired;
    logic                          fill_expired;
    logic                          sal_bad;

    // saturating tick count, shared by both phase timeouts
    assign elapsed_inc   = (&elapsed) ? elapsed : elapsed + 1'b1;
    assign drain_expired = (elapsed_inc >= cfg.drain_limit);
    assign fill_expired  = (elapsed_inc >= cfg.fill_limit);
    assign sal_bad       = cfg.salt_mode &&
                           ((item.barrel_salinity < cfg.salinity_min) ||
                            (item.barrel_salinity > cfg.salinity_max));

    always_comb
    begin
        phase_next   = phase;
        elapsed_next = elapsed;
        ev           = dfs_pkg::EV_NONE;
        unique case (item.operation)
            dfs_pkg::OP_ABORT:
            begin
                phase_next   = dfs_pkg::PH_IDLE;
                elapsed_next = '0;
                ev           = dfs_pkg::EV_ABORTED;
            end
            dfs_pkg::OP_START:
            begin
                if (phase == dfs_pkg::PH_IDLE)
                begin
                    priority if (sal_bad)
                        ev = dfs_pkg::EV_SKIP_SAL;
                    else if (item.tank_level_low || item.barrel_level_low)
                        ev = dfs_pkg::EV_SKIP_LEVEL;
                    else
                    begin
                        phase_next   = dfs_pkg::PH_DRAIN;
                        elapsed_next = '0;
                        ev           = dfs_pkg::EV_STARTED;
                    end
                end
            end
            dfs_pkg::OP_TICK:
            begin
                unique case (phase)
                    dfs_pkg::PH_DRAIN:
                    begin
                        priority if (item.tank_low_hit)
                        begin
                            phase_next   = dfs_pkg::PH_FILL;
                            elapsed_next = '0;
                            ev           = dfs_pkg::EV_DRAIN_DONE;
                        end
                        else if (drain_expired)
                        begin
                            phase_next   = dfs_pkg::PH_FILL;
                            elapsed_next = '0;
                            ev           = dfs_pkg::EV_DRAIN_TMO;
                        end
                        else
                            elapsed_next = elapsed_inc;
                    end
                    dfs_pkg::PH_FILL:
                    begin
                        priority if (item.tank_high_hit)
                        begin
                            phase_next   = dfs_pkg::PH_IDLE;
                            elapsed_next = '0;
                            ev           = dfs_pkg::EV_FILL_DONE;
                        end
                        else if (item.barrel_low_hit)
                        begin
                            phase_next   = dfs_pkg::PH_IDLE;
                            elapsed_next = '0;
                            ev           = dfs_pkg::EV_BARREL_LOW;
                        end
                        else if (fill_expired)
                        begin
                            phase_next   = dfs_pkg::PH_IDLE;
                            elapsed_next = '0;
                            ev           = dfs_pkg::EV_FILL_TMO;
                        end
                        else
                            elapsed_next = elapsed_inc;
                    end
                    default: phase_next = dfs_pkg::PH_IDLE;
                endcase
            end
            default: ;   // reserved operation code: no effect
        endcase
    end

endmodule

/* src/drain_fill_sequencer.sv */
// ----------------------------------------------------------------------------
// drain_fill_sequencer: water-change drain/fill sequencer
// Steps a drain-then-fill sequence on tick, start and abort transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one command per transaction: s_tuser holds the
//   operation (tick, start, abort); s_tdata holds the level switches, level
//   classes and barrel salinity. Every input transaction yields exactly one
//   master-stream (m_*) transaction with the pump states, the phase after
//   the command and an event code. Configuration (salt mode, salinity window,
//   drain/fill tick limits) is written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the block is idle, which it does not enforce.
// Pipeline and throughput:
//   A command lands in an input register, the next-state logic runs
//   combinationally and the result is registered. One transaction per cycle
//   is sustained while m_tready stays high; the phase and tick count update
//   in the same cycle the command leaves the input register.
// Reset:
//   rst_n (async, active low) returns the phase to idle, clears the tick
//   count, empties both stages and restores the register defaults.
// Stall:
//   While m_tready is low the result stays on m_tdata and one more command
//   is held in the input register; s_tready then drops until the output
//   moves again.
// ----------------------------------------------------------------------------
module drain_fill_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [0] tank_low_hit, [1] tank_high_hit, [2] barrel_low_hit,
    // [3] tank_level_low, [4] barrel_level_low, [20:5] barrel_salinity
    input  logic [23:0]                           s_tdata,
    // [1:0] operation
    input  logic [1:0]                            s_tuser,
    // master stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] drain_on, [1] fill_on, [3:2] phase, [7:4] event_code
    output logic [7:0]                            m_tdata,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [dfs_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [dfs_pkg::CfgDataWidth-1:0]      cfg_data
);

    dfs_pkg::cfg_t                  cfg;

    // input stage
    logic                           in_valid_reg;
    dfs_pkg::item_t                 item_reg;

    // sequencer state
    dfs_pkg::phase_t                phase_reg;
    dfs_pkg::phase_t                phase_next;
    logic [dfs_pkg::TickWidth-1:0]  elapsed_reg;
    logic [dfs_pkg::TickWidth-1:0]  elapsed_next;
    dfs_pkg::event_t                ev_next;

    // result stage
    logic                           out_valid_reg;
    dfs_pkg::phase_t                out_phase_reg;
    dfs_pkg::event_t                out_event_reg;

    logic                           advance;
    logic                           s_xfer;

    // input stage moves forward when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    dfs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfs_step u_step
    (
        .cfg          (cfg),
        .item         (item_reg),
        .phase        (phase_reg),
        .elapsed      (elapsed_reg),
        .phase_next   (phase_next),
        .elapsed_next (elapsed_next),
        .ev           (ev_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg.operation        <= s_tuser;
            item_reg.tank_low_hit     <= s_tdata[0];
            item_reg.tank_high_hit    <= s_tdata[1];
            item_reg.barrel_low_hit   <= s_tdata[2];
            item_reg.tank_level_low   <= s_tdata[3];
            item_reg.barrel_level_low <= s_tdata[4];
            item_reg.barrel_salinity  <= s_tdata[20:5];
        end
    end

    // state and result register: both update on the same command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dfs_pkg::PH_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg <= phase_next;
            out_event_reg <= ev_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_event_reg,
                       out_phase_reg,
                       out_phase_reg == dfs_pkg::PH_FILL,
                       out_phase_reg == dfs_pkg::PH_DRAIN};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // state only moves when a command is consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(elapsed_reg))
        else $error("sequencer state changed without a command");

    // the tick count is always cleared while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dfs_pkg::PH_IDLE |-> elapsed_reg == '0)
        else $error("tick count nonzero in idle");

    // an abort result always reports idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_event_reg == dfs_pkg::EV_ABORTED
            |-> out_phase_reg == dfs_pkg::PH_IDLE)
        else $error("abort result not idle");

    // a start result always reports drain, and matches the live phase
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && ev_next == dfs_pkg::EV_STARTED
            |=> phase_reg == dfs_pkg::PH_DRAIN && out_phase_reg == dfs_pkg::PH_DRAIN)
        else $error("start did not enter drain");

    // a drain end always lands in fill
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (ev_next == dfs_pkg::EV_DRAIN_DONE || ev_next == dfs_pkg::EV_DRAIN_TMO)
            |=> phase_reg == dfs_pkg::PH_FILL)
        else $error("drain end did not enter fill");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the drain/fill sequencer
// Drives directed and random commands into the slave stream across several
// register settings and idle patterns. A scoreboard predicts each status
// transaction and compares it, field by field, on the master stream.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transaction
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned PHASE_ITEMS = 180;
    localparam int unsigned PLAN_COUNT  = 6;

    // Operation code the block must ignore
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Sensor flags, same order as s_tdata[4:0]
    localparam logic [4:0] FLAG_NONE       = 5'b00000;
    localparam logic [4:0] FLAG_TANK_LOW   = 5'b00001;
    localparam logic [4:0] FLAG_TANK_HIGH  = 5'b00010;
    localparam logic [4:0] FLAG_BARREL_HIT = 5'b00100;
    localparam logic [4:0] FLAG_TANK_LVL   = 5'b01000;
    localparam logic [4:0] FLAG_BARREL_LVL = 5'b10000;

    // Matches m_tdata: [0] drain_on, [1] fill_on, [3:2] phase, [7:4] event
    typedef struct packed {
        dfs_pkg::event_t code;
        dfs_pkg::phase_t phase;
        logic            fill_on;
        logic            drain_on;
    } status_t;

    // Tracks sequencer phase and tick count, queues predicted status
    class pump_status_board;
        dfs_pkg::cfg_t                 regs;
        dfs_pkg::phase_t               phase;
        logic [dfs_pkg::TickWidth-1:0] elapsed;
        status_t                       status_q[$];
        int unsigned                   errors;

        function new();
            regs.salt_mode    = 1'b0;
            regs.salinity_min = dfs_pkg::SALINITY_MIN_RST;
            regs.salinity_max = dfs_pkg::SALINITY_MAX_RST;
            regs.drain_limit  = dfs_pkg::DRAIN_LIMIT_RST;
            regs.fill_limit   = dfs_pkg::FILL_LIMIT_RST;
            phase             = dfs_pkg::PH_IDLE;
            elapsed           = '0;
            errors            = 0;
        endfunction

        function void set_reg(logic [dfs_pkg::CfgIndexWidth-1:0] idx,
                              logic [dfs_pkg::CfgDataWidth-1:0] val);
            case (idx)
                dfs_pkg::CFG_SALT_MODE:    regs.salt_mode    = val[0];
                dfs_pkg::CFG_SALINITY_MIN: regs.salinity_min = val[dfs_pkg::SalWidth-1:0];
                dfs_pkg::CFG_SALINITY_MAX: regs.salinity_max = val[dfs_pkg::SalWidth-1:0];
                dfs_pkg::CFG_DRAIN_LIMIT:  regs.drain_limit  = val[dfs_pkg::TickWidth-1:0];
                dfs_pkg::CFG_FILL_LIMIT:   regs.fill_limit   = val[dfs_pkg::TickWidth-1:0];
                default: ;
            endcase
        endfunction

        // saturating count; true once the phase limit is reached
        function bit count_expired(logic [dfs_pkg::TickWidth-1:0] limit);
            if (elapsed != '1)
                elapsed = elapsed + 1'b1;
            return elapsed >= limit;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("[%0t] status mismatch: %s", $time, msg);
        endfunction

        // Accepted command: advance the sequencer and queue its status
        function void log_command(dfs_pkg::item_t cmd);
            dfs_pkg::event_t code;
            status_t         st;
            code = dfs_pkg::EV_NONE;
            case (cmd.operation)
                dfs_pkg::OP_ABORT:
                begin
                    phase   = dfs_pkg::PH_IDLE;
                    elapsed = '0;
                    code    = dfs_pkg::EV_ABORTED;
                end
                dfs_pkg::OP_START:
                begin
                    if (phase == dfs_pkg::PH_IDLE)
                    begin
                        if (regs.salt_mode && (cmd.barrel_salinity < regs.salinity_min ||
                                               cmd.barrel_salinity > regs.salinity_max))
                            code = dfs_pkg::EV_SKIP_SAL;
                        else if (cmd.tank_level_low || cmd.barrel_level_low)
                            code = dfs_pkg::EV_SKIP_LEVEL;
                        else
                        begin
                            phase   = dfs_pkg::PH_DRAIN;
                            elapsed = '0;
                            code    = dfs_pkg::EV_STARTED;
                        end
                    end
                end
                dfs_pkg::OP_TICK:
                begin
                    if (phase == dfs_pkg::PH_DRAIN)
                    begin
                        if (cmd.tank_low_hit)
                            code = dfs_pkg::EV_DRAIN_DONE;
                        else if (count_expired(regs.drain_limit))
                            code = dfs_pkg::EV_DRAIN_TMO;
                        // fill follows drain even after a timeout
                        if (code != dfs_pkg::EV_NONE)
                        begin
                            phase   = dfs_pkg::PH_FILL;
                            elapsed = '0;
                        end
                    end
                    else if (phase == dfs_pkg::PH_FILL)
                    begin
                        if (cmd.tank_high_hit)
                            code = dfs_pkg::EV_FILL_DONE;
                        else if (cmd.barrel_low_hit)
                            code = dfs_pkg::EV_BARREL_LOW;
                        else if (count_expired(regs.fill_limit))
                            code = dfs_pkg::EV_FILL_TMO;
                        if (code != dfs_pkg::EV_NONE)
                        begin
                            phase   = dfs_pkg::PH_IDLE;
                            elapsed = '0;
                        end
                    end
                end
                default: ;  // reserved op: no effect
            endcase
            st.code     = code;
            st.phase    = phase;
            st.fill_on  = (phase == dfs_pkg::PH_FILL);
            st.drain_on = (phase == dfs_pkg::PH_DRAIN);
            status_q.push_back(st);
        endfunction

        function void check_status(logic [7:0] raw);
            status_t got;
            status_t want;
            got = status_t'(raw);
            if (status_q.size() == 0)
            begin
                report($sformatf("unexpected status %h, nothing pending", raw));
                return;
            end
            want = status_q.pop_front();
            if (got.drain_on !== want.drain_on || got.fill_on !== want.fill_on ||
                got.phase !== want.phase || got.code !== want.code)
                report($sformatf({"expected drain %0d fill %0d phase %0d event %0d, ",
                                  "got drain %0d fill %0d phase %0d event %0d"},
                                 want.drain_on, want.fill_on, want.phase, want.code,
                                 got.drain_on, got.fill_on, got.phase, got.code));
        endfunction
    endclass

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [23:0]                       s_tdata   = '0;
    logic [1:0]                        s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [7:0]                        m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [dfs_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [dfs_pkg::CfgDataWidth-1:0]  cfg_data  = '0;

    int unsigned sender_idle_pct   = 6;
    int unsigned receiver_idle_pct = 84;
    int unsigned quiet_cycles      = 0;

    pump_status_board board = new();

    drain_fill_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Status sink with random backpressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_status(m_tdata);
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: ends a run that stops moving transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One command transaction; s_tvalid stays high on return
    task automatic send_fields(input logic [1:0] op, input logic [4:0] flags,
                               input logic [dfs_pkg::SalWidth-1:0] sal);
        dfs_pkg::item_t cmd;
        cmd.operation        = op;
        cmd.tank_low_hit     = flags[0];
        cmd.tank_high_hit    = flags[1];
        cmd.barrel_low_hit   = flags[2];
        cmd.tank_level_low   = flags[3];
        cmd.barrel_level_low = flags[4];
        cmd.barrel_salinity  = sal;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, sal, flags};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.log_command(cmd);
    endtask

    // Mostly well-formed sequences: starts in idle, ticks while running
    task automatic send_random();
        logic [1:0]                   op;
        logic [4:0]                   flags;
        logic [dfs_pkg::SalWidth-1:0] sal;
        int unsigned                  roll;
        roll = $urandom_range(99);
        if (board.phase == dfs_pkg::PH_IDLE)
            op = (roll < 70) ? dfs_pkg::OP_START : (roll < 85) ? dfs_pkg::OP_TICK :
                 (roll < 95) ? dfs_pkg::OP_ABORT : OP_RESERVED;
        else
            op = (roll < 86) ? dfs_pkg::OP_TICK : (roll < 91) ? dfs_pkg::OP_START :
                 (roll < 96) ? dfs_pkg::OP_ABORT : OP_RESERVED;
        flags[0] = ($urandom_range(99) < 12);
        flags[1] = ($urandom_range(99) < 12);
        flags[2] = ($urandom_range(99) < 8);
        flags[3] = ($urandom_range(99) < 8);
        flags[4] = ($urandom_range(99) < 8);
        if ($urandom_range(99) < 80)
            sal = 16'($urandom_range(board.regs.salinity_max, board.regs.salinity_min));
        else
            sal = 16'($urandom_range(65535));
        send_fields(op, flags, sal);
    endtask

    // Drop valid and wait for every pending status, plus the pipe depth
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // All five registers, then one unmapped index that must be ignored
    task automatic write_settings(input dfs_pkg::cfg_t c);
        logic [dfs_pkg::CfgIndexWidth-1:0] idx [6];
        logic [dfs_pkg::CfgDataWidth-1:0]  val [6];
        logic [31:0]                       noise;
        noise = $urandom;
        idx = '{dfs_pkg::CFG_SALT_MODE, dfs_pkg::CFG_SALINITY_MIN,
                dfs_pkg::CFG_SALINITY_MAX, dfs_pkg::CFG_DRAIN_LIMIT,
                dfs_pkg::CFG_FILL_LIMIT,
                dfs_pkg::CFG_FILL_LIMIT + 3'($urandom_range(3, 1))};
        // unused upper data bits carry noise
        val = '{{noise[31:1], c.salt_mode}, {noise[31:16], c.salinity_min},
                {noise[15:0], c.salinity_max}, c.drain_limit, c.fill_limit, $urandom};
        foreach (idx[i])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            board.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        dfs_pkg::cfg_t plan [PLAN_COUNT];
        dfs_pkg::cfg_t directed;
        plan = '{
            '{1'b0, 16'd0,     16'hFFFF,  32'd5,        32'd4},
            '{1'b1, 16'd1000,  16'd3000,  32'd0,        32'd0},
            '{1'b1, 16'd0,     16'hFFFF,  32'd1,        32'd7},
            '{1'b1, 16'd40000, 16'd40000, 32'd3,        32'd2},
            '{1'b0, 16'hFFFF,  16'd0,     32'hFFFFFFFF, 32'hFFFFFFFF},
            '{1'b1, 16'd500,   16'hFFFF,  32'd8,        32'd6}
        };
        directed = '{1'b1, 16'd100, 16'd200, 32'd2, 32'd3};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: no salinity check, long limits
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd0);
        send_fields(dfs_pkg::OP_TICK, FLAG_NONE, 16'hFFFF);
        send_fields(dfs_pkg::OP_ABORT, 5'b11111, 16'hFFFF);
        settle();

        // window 100..200, drain times out on 2nd tick, fill on 3rd
        write_settings(directed);
        send_fields(dfs_pkg::OP_TICK, FLAG_NONE, 16'd0);          // tick in idle
        send_fields(dfs_pkg::OP_ABORT, FLAG_NONE, 16'd0);         // abort in idle
        send_fields(OP_RESERVED, 5'b11111, 16'hFFFF);
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd99);        // below window
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd201);       // above window
        send_fields(dfs_pkg::OP_START, FLAG_TANK_LVL, 16'd100);
        send_fields(dfs_pkg::OP_START, FLAG_BARREL_LVL, 16'd200);
        // salinity wins
        send_fields(dfs_pkg::OP_START, FLAG_TANK_LVL | FLAG_BARREL_LVL, 16'hFFFF);
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd150);
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd150);       // start while busy
        send_fields(OP_RESERVED, FLAG_NONE, 16'd150);
        send_fields(dfs_pkg::OP_TICK, FLAG_TANK_HIGH | FLAG_BARREL_HIT, 16'd150);
        send_fields(dfs_pkg::OP_TICK, FLAG_NONE, 16'd150);  // drain timeout, fill anyway
        send_fields(dfs_pkg::OP_TICK, FLAG_TANK_HIGH | FLAG_BARREL_HIT, 16'd150);
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd150);
        send_fields(dfs_pkg::OP_TICK, FLAG_TANK_LOW, 16'd150);    // drain done
        send_fields(dfs_pkg::OP_TICK, FLAG_BARREL_HIT | FLAG_TANK_LOW, 16'd150);
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd150);
        send_fields(dfs_pkg::OP_TICK, FLAG_TANK_LOW, 16'd150);
        repeat (3) send_fields(dfs_pkg::OP_TICK, FLAG_TANK_LOW, 16'd150); // fill timeout
        send_fields(dfs_pkg::OP_START, FLAG_NONE, 16'd150);
        send_fields(dfs_pkg::OP_ABORT, FLAG_NONE, 16'd150);       // abort while draining

        // random phases: receiver idles, then sender idles, then neither
        for (int p = 0; p < PLAN_COUNT; p++)
        begin
            case (p / 2)
                0:       begin sender_idle_pct = 6;  receiver_idle_pct = 84; end
                1:       begin sender_idle_pct = 84; receiver_idle_pct = 6;  end
                default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
            endcase
            settle();
            write_settings(plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_random();
                if (n == PHASE_ITEMS / 2)
                    settle();  // hold off until the pipe is empty
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.status_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
src/dfs_pkg.sv
src/dfs_cfg_regs.sv
src/dfs_step.sv
src/drain_fill_sequencer.sv
bench/tb_top.sv
